>>> rtl/cjpid_pkg.sv
// Types, constants and arithmetic helpers for the cascaded joint PID controller.
package cjpid_pkg;

    localparam int ANGLE_BITS = 24;
    localparam int VEL_BITS   = 24;
    localparam int PCT_BITS   = 16;
    localparam int GAIN_BITS  = 16;
    localparam int RATE_BITS  = 14;
    localparam int PWM_BITS   = 15;
    localparam int WIDE_BITS  = 64;
    localparam int CFG_BITS   = 16;
    localparam int IDX_BITS   = 3;

    typedef logic signed [WIDE_BITS-1:0] wide_t;

    localparam wide_t V_MAX       = 64'sd8388607;
    localparam wide_t V_MIN       = -64'sd8388608;
    localparam wide_t TOL_Q8      = 64'sd256;
    localparam wide_t POS_ZONE_Q8 = 64'sd1920;
    localparam wide_t VEL_ZONE_Q8 = 64'sd7680;
    localparam wide_t TARGET_VMAX = 64'sd46080;
    localparam wide_t ANGLE_LIMIT = 64'sd46080;

    localparam logic [GAIN_BITS-1:0] ALPHA_Q16 = 16'd9830;
    localparam logic [GAIN_BITS-1:0] DECAY_Q16 = 16'd62259;
    localparam logic [15:0]          SLEW_NUM  = 16'd51200;

    localparam logic [IDX_BITS-1:0] REG_POS_KP  = 3'd0;
    localparam logic [IDX_BITS-1:0] REG_POS_KI  = 3'd1;
    localparam logic [IDX_BITS-1:0] REG_POS_KD  = 3'd2;
    localparam logic [IDX_BITS-1:0] REG_VEL_KP  = 3'd3;
    localparam logic [IDX_BITS-1:0] REG_VEL_KI  = 3'd4;
    localparam logic [IDX_BITS-1:0] REG_VEL_KD  = 3'd5;
    localparam logic [IDX_BITS-1:0] REG_RATE    = 3'd6;
    localparam logic [IDX_BITS-1:0] REG_MAX_PWM = 3'd7;

    typedef struct packed {
        logic                         kind;
        logic signed [ANGLE_BITS-1:0] commanded_angle;
        logic signed [ANGLE_BITS-1:0] measured_angle;
        logic signed [PCT_BITS-1:0]   gravity_term;
        logic                         feedback_enabled;
    } in_item_t;

    typedef struct packed {
        logic signed [PCT_BITS-1:0] pwm_percent;
        logic signed [VEL_BITS-1:0] target_velocity;
        logic signed [VEL_BITS-1:0] filtered_velocity;
        logic                       within_tolerance;
        logic                       output_clamped;
        logic                       slew_limited;
    } out_item_t;

    function automatic wide_t mag(input wide_t x);
        return x[WIDE_BITS-1] ? -x : x;
    endfunction

    function automatic wide_t sat(input wide_t x, input wide_t lo, input wide_t hi);
        return (x < lo) ? lo : ((x > hi) ? hi : x);
    endfunction

    // round half away from zero
    function automatic wide_t rnd_shr(input wide_t x, input int unsigned s);
        logic [WIDE_BITS-1:0] m;
        m = x[WIDE_BITS-1] ? WIDE_BITS'(-x) : WIDE_BITS'(x);
        m = (m + (64'd1 << (s - 1))) >> s;
        return x[WIDE_BITS-1] ? -wide_t'(m) : wide_t'(m);
    endfunction

endpackage

>>> rtl/cascaded_joint_pid_controller_top.sv
// Cascaded position/velocity PID controller, bit-serial multiply and divide sequencer.
// Sequence: 11 serial multiplies on the single shift-add multiplier, a bit-serial divide
// and a shaping step; a clear item goes straight to the shaping step.
// A new item is taken only once the sequencer is idle again and the last result is
// registered; a result still waiting on the output holds off the next item.
// Reset: asynchronous active low; gains and limits load defaults, loop state clears.
module cascaded_joint_pid_controller_top
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  cjpid_pkg::in_item_t                 in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output cjpid_pkg::out_item_t                out_data,
    input  logic                                cfg_we,
    input  logic [cjpid_pkg::IDX_BITS-1:0]      cfg_index,
    input  logic [cjpid_pkg::CFG_BITS-1:0]      cfg_data
);
    import cjpid_pkg::*;

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_LOAD  = 3'd1;
    localparam logic [2:0] PH_MUL   = 3'd2;
    localparam logic [2:0] PH_FIN   = 3'd3;
    localparam logic [2:0] PH_DIV   = 3'd4;
    localparam logic [2:0] PH_SHAPE = 3'd5;

    localparam logic [3:0] ST_TRAJ = 4'd0;
    localparam logic [3:0] ST_RAW  = 4'd1;
    localparam logic [3:0] ST_FILT = 4'd2;
    localparam logic [3:0] ST_PDEC = 4'd3;
    localparam logic [3:0] ST_PP   = 4'd4;
    localparam logic [3:0] ST_PI   = 4'd5;
    localparam logic [3:0] ST_PD   = 4'd6;
    localparam logic [3:0] ST_VDEC = 4'd7;
    localparam logic [3:0] ST_VP   = 4'd8;
    localparam logic [3:0] ST_VI   = 4'd9;
    localparam logic [3:0] ST_VD   = 4'd10;

    logic [GAIN_BITS-1:0] pkp_reg, pki_reg, pkd_reg, vkp_reg, vki_reg, vkd_reg;
    logic [RATE_BITS-1:0] rate_cfg_reg;
    logic [PWM_BITS-1:0]  max_pwm_reg;

    logic [2:0] phase_reg;
    logic [3:0] step_reg;
    logic [3:0] cnt_reg;
    logic       clr_reg;

    logic signed [ANGLE_BITS-1:0] prev_meas_reg, prev_cmd_reg, cmd_reg, meas_reg;
    logic signed [VEL_BITS-1:0]   ve_reg, traj_reg, prev_verr_reg, pint_reg, vint_reg;
    logic signed [VEL_BITS-1:0]   raw_reg, tv_reg;
    logic signed [PCT_BITS-1:0]   prev_out_reg, grav_reg;
    logic [2:0]                   init_reg;
    logic [1:0]                   satf_reg;
    logic                         fb_reg, within_reg;
    logic [RATE_BITS-1:0]         rate_reg;
    logic signed [ANGLE_BITS:0]   err_reg;
    logic signed [VEL_BITS:0]     vrate_reg;
    wide_t                        acc_reg, pid_reg;

    wide_t                        ma_reg, macc_reg;
    logic [GAIN_BITS-1:0]         mb_reg;

    logic [15:0]                  dvd_reg, quo_reg;
    logic [RATE_BITS:0]           rem_reg;

    logic                         out_valid_reg;
    out_item_t                    out_reg;

    wide_t                op_a;
    logic [GAIN_BITS-1:0] op_b;
    wide_t r8, r16, limp, limv, err_w, pint_t, pint_next, vint_t, vint_next;
    wide_t unc, tv_next, verr_next;
    wide_t pidf, total, clamped, outv, stepv, mo;
    logic  slew, reversing, out_free, acc_in;
    logic [RATE_BITS:0] rem_sh;
    logic [RATE_BITS-1:0] rate_in;

    assign in_ready  = (phase_reg == PH_IDLE);
    assign acc_in    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign out_free  = !out_valid_reg || out_ready;
    assign rate_in   = (rate_cfg_reg == '0) ? RATE_BITS'(1) : rate_cfg_reg;

    always_comb
    begin
        unique case (step_reg)
            ST_TRAJ: begin op_a = init_reg[1] ? wide_t'(cmd_reg) - wide_t'(prev_cmd_reg)
                                               : '0;
                           op_b = GAIN_BITS'(rate_reg); end
            ST_RAW:  begin op_a = wide_t'(meas_reg) - wide_t'(prev_meas_reg);
                           op_b = GAIN_BITS'(rate_reg); end
            ST_FILT: begin op_a = wide_t'(raw_reg) - wide_t'(ve_reg); op_b = ALPHA_Q16; end
            ST_PDEC: begin op_a = wide_t'(pint_reg); op_b = DECAY_Q16; end
            ST_PP:   begin op_a = within_reg ? '0 : wide_t'(err_reg); op_b = pkp_reg; end
            ST_PI:   begin op_a = wide_t'(pint_reg); op_b = pki_reg; end
            ST_PD:   begin op_a = within_reg ? '0 : wide_t'(traj_reg) - wide_t'(ve_reg);
                           op_b = pkd_reg; end
            ST_VDEC: begin op_a = wide_t'(vint_reg); op_b = DECAY_Q16; end
            ST_VP:   begin op_a = wide_t'(prev_verr_reg); op_b = vkp_reg; end
            ST_VI:   begin op_a = wide_t'(vint_reg); op_b = vki_reg; end
            ST_VD:   begin op_a = wide_t'(vrate_reg); op_b = vkd_reg; end
            default: begin op_a = '0; op_b = '0; end
        endcase
    end

    always_comb
    begin
        r8    = rnd_shr(macc_reg, 8);
        r16   = rnd_shr(macc_reg, 16);
        limp  = sat((wide_t'(rate_reg) <<< 10) + (wide_t'(rate_reg) <<< 8), '0, V_MAX);
        limv  = sat((wide_t'(rate_reg) <<< 13) - (wide_t'(rate_reg) <<< 9), '0, V_MAX);
        err_w = wide_t'(err_reg);

        if (!fb_reg)
            pint_t = '0;
        else if (!within_reg)
            pint_t = (mag(err_w) < POS_ZONE_Q8 && !satf_reg[0])
                     ? wide_t'(pint_reg) + err_w : r16;
        else
            pint_t = wide_t'(pint_reg);
        pint_next = sat(pint_t, -limp, limp);

        unc       = acc_reg + r8;
        tv_next   = sat(unc, -TARGET_VMAX, TARGET_VMAX);
        verr_next = sat(tv_next - wide_t'(ve_reg), V_MIN, V_MAX);

        if (!fb_reg)
            vint_t = '0;
        else if (mag(wide_t'(prev_verr_reg)) < VEL_ZONE_Q8 && !satf_reg[1])
            vint_t = wide_t'(vint_reg) + wide_t'(prev_verr_reg);
        else
            vint_t = r16;
        vint_next = sat(vint_t, -limv, limv);

        pidf    = fb_reg ? pid_reg : '0;
        total   = pidf + wide_t'(grav_reg);
        clamped = sat(total, -wide_t'(max_pwm_reg), wide_t'(max_pwm_reg));
        stepv   = wide_t'(quo_reg);
        reversing = (clamped != '0) && (prev_out_reg != '0)
                    && (clamped[WIDE_BITS-1] != prev_out_reg[PCT_BITS-1]);
        outv = clamped;
        slew = 1'b0;
        mo   = mag(wide_t'(prev_out_reg)) + stepv;
        if (!reversing && mag(clamped) > mag(wide_t'(prev_out_reg)))
        begin
            if (mo > mag(clamped))
                mo = mag(clamped);
            outv = clamped[WIDE_BITS-1] ? -mo : mo;
            slew = (outv != clamped);
        end
        if ((wide_t'(meas_reg) <= -ANGLE_LIMIT && outv < 0) ||
            (wide_t'(meas_reg) >= ANGLE_LIMIT && outv > 0))
            outv = '0;

        rem_sh = {rem_reg[RATE_BITS-1:0], dvd_reg[15]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pkp_reg      <= 16'd1280;
            pki_reg      <= '0;
            pkd_reg      <= '0;
            vkp_reg      <= 16'd51;
            vki_reg      <= '0;
            vkd_reg      <= '0;
            rate_cfg_reg <= 14'd250;
            max_pwm_reg  <= 15'd15360;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_POS_KP:  pkp_reg      <= cfg_data;
                REG_POS_KI:  pki_reg      <= cfg_data;
                REG_POS_KD:  pkd_reg      <= cfg_data;
                REG_VEL_KP:  vkp_reg      <= cfg_data;
                REG_VEL_KI:  vki_reg      <= cfg_data;
                REG_VEL_KD:  vkd_reg      <= cfg_data;
                REG_RATE:    rate_cfg_reg <= cfg_data[RATE_BITS-1:0];
                REG_MAX_PWM: max_pwm_reg  <= cfg_data[PWM_BITS-1:0];
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            step_reg      <= ST_TRAJ;
            cnt_reg       <= '0;
            clr_reg       <= 1'b0;
            prev_meas_reg <= '0;
            prev_cmd_reg  <= '0;
            ve_reg        <= '0;
            traj_reg      <= '0;
            prev_verr_reg <= '0;
            pint_reg      <= '0;
            vint_reg      <= '0;
            prev_out_reg  <= '0;
            init_reg      <= '0;
            satf_reg      <= '0;
            tv_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready && (phase_reg != PH_SHAPE))
                out_valid_reg <= 1'b0;

            unique case (phase_reg)
                PH_IDLE:
                begin
                    if (acc_in)
                    begin
                        cmd_reg    <= in_data.commanded_angle;
                        meas_reg   <= in_data.measured_angle;
                        grav_reg   <= in_data.gravity_term;
                        fb_reg     <= in_data.feedback_enabled;
                        rate_reg   <= rate_in;
                        err_reg    <= (ANGLE_BITS+1)'(wide_t'(in_data.commanded_angle)
                                       - wide_t'(in_data.measured_angle));
                        within_reg <= mag(wide_t'(in_data.commanded_angle)
                                       - wide_t'(in_data.measured_angle)) <= TOL_Q8;
                        step_reg   <= ST_TRAJ;
                        if (in_data.kind)
                        begin
                            ve_reg        <= '0;
                            traj_reg      <= '0;
                            prev_verr_reg <= '0;
                            pint_reg      <= '0;
                            vint_reg      <= '0;
                            prev_out_reg  <= '0;
                            init_reg      <= '0;
                            satf_reg      <= '0;
                            tv_reg        <= '0;
                            clr_reg       <= 1'b1;
                            phase_reg     <= PH_SHAPE;
                        end
                        else
                        begin
                            if (!init_reg[0])
                            begin
                                prev_meas_reg <= in_data.measured_angle;
                                ve_reg        <= '0;
                            end
                            init_reg[0] <= 1'b1;
                            clr_reg     <= 1'b0;
                            phase_reg   <= PH_LOAD;
                        end
                    end
                end
                PH_LOAD:
                begin
                    ma_reg    <= op_a;
                    mb_reg    <= op_b;
                    macc_reg  <= '0;
                    cnt_reg   <= '0;
                    phase_reg <= PH_MUL;
                end
                PH_MUL:
                begin
                    if (mb_reg[0])
                        macc_reg <= macc_reg + ma_reg;
                    ma_reg  <= ma_reg <<< 1;
                    mb_reg  <= mb_reg >> 1;
                    cnt_reg <= cnt_reg + 4'd1;
                    if (cnt_reg == 4'd15)
                        phase_reg <= PH_FIN;
                end
                PH_FIN:
                begin
                    step_reg  <= step_reg + 4'd1;
                    phase_reg <= PH_LOAD;
                    unique case (step_reg)
                        ST_TRAJ:
                        begin
                            traj_reg     <= VEL_BITS'(sat(macc_reg, V_MIN, V_MAX));
                            init_reg[1]  <= 1'b1;
                            prev_cmd_reg <= cmd_reg;
                        end
                        ST_RAW:
                        begin
                            raw_reg       <= VEL_BITS'(sat(macc_reg, V_MIN, V_MAX));
                            prev_meas_reg <= meas_reg;
                        end
                        ST_FILT: ve_reg <= VEL_BITS'(sat(wide_t'(ve_reg) + r16,
                                                         V_MIN, V_MAX));
                        ST_PDEC: pint_reg <= pint_next[VEL_BITS-1:0];
                        ST_PP:   acc_reg <= wide_t'(traj_reg) + r8;
                        ST_PI:   acc_reg <= acc_reg + r8;
                        ST_PD:
                        begin
                            tv_reg        <= tv_next[VEL_BITS-1:0];
                            satf_reg[0]   <= (tv_next != unc);
                            vrate_reg     <= init_reg[2]
                                ? (VEL_BITS+1)'(verr_next - wide_t'(prev_verr_reg)) : '0;
                            init_reg[2]   <= 1'b1;
                            prev_verr_reg <= verr_next[VEL_BITS-1:0];
                        end
                        ST_VDEC: vint_reg <= vint_next[VEL_BITS-1:0];
                        ST_VP:   pid_reg <= r8;
                        ST_VI:   pid_reg <= pid_reg + r8;
                        ST_VD:
                        begin
                            pid_reg   <= pid_reg + r8;
                            dvd_reg   <= SLEW_NUM;
                            rem_reg   <= '0;
                            cnt_reg   <= '0;
                            phase_reg <= PH_DIV;
                        end
                        default: ;
                    endcase
                end
                PH_DIV:
                begin
                    dvd_reg <= dvd_reg << 1;
                    cnt_reg <= cnt_reg + 4'd1;
                    if (rem_sh >= (RATE_BITS+1)'(rate_reg))
                    begin
                        rem_reg <= rem_sh - (RATE_BITS+1)'(rate_reg);
                        quo_reg <= {quo_reg[14:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh;
                        quo_reg <= {quo_reg[14:0], 1'b0};
                    end
                    if (cnt_reg == 4'd15)
                        phase_reg <= PH_SHAPE;
                end
                PH_SHAPE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        phase_reg     <= PH_IDLE;
                        if (clr_reg)
                            out_reg <= '0;
                        else
                        begin
                            out_reg.pwm_percent       <= outv[PCT_BITS-1:0];
                            out_reg.target_velocity   <= fb_reg ? tv_reg : '0;
                            out_reg.filtered_velocity <= ve_reg;
                            out_reg.within_tolerance  <= within_reg;
                            out_reg.output_clamped    <= (clamped != total);
                            out_reg.slew_limited      <= slew;
                            prev_out_reg              <= outv[PCT_BITS-1:0];
                            satf_reg[1]               <= (clamped != total) || slew;
                        end
                    end
                end
                default: phase_reg <= PH_IDLE;
            endcase
        end
    end

    a_init_order: assert property (@(posedge clk) disable iff (!rst_n)
        init_reg[2] |-> (init_reg[1] && init_reg[0]))
        else $error("velocity error primed before filter and command");

    a_tv_range: assert property (@(posedge clk) disable iff (!rst_n)
        (wide_t'(tv_reg) <= TARGET_VMAX) && (wide_t'(tv_reg) >= -TARGET_VMAX))
        else $error("target velocity beyond limit");

    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(phase_reg) == PH_SHAPE))
        else $error("result raised outside shaping phase");

endmodule
